// File: rtl/core/wcc_pkg.sv
// Shared types, codes and constants of the weighted coverage counter.
`default_nettype none
package wcc_pkg;

   localparam int OP_BITS     = 3;
   localparam int INDEX_BITS  = 12;
   localparam int WEIGHT_BITS = 32;
   localparam int ACC_BITS    = 48;

   localparam int DEF_NUM_NEIGHBORS = 4096;
   localparam int DEF_COUNT_BITS    = 16;

   // Q16.16 value of 1.0, the weight every neighbor starts with.
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 32'h0001_0000;
   localparam logic [ACC_BITS-1:0]    ACC_MAX    = {ACC_BITS{1'b1}};

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE_WEIGHT = 3'd0,
      OP_GAIN_ADD     = 3'd1,
      OP_GAIN_REMOVE  = 3'd2,
      OP_ADD          = 3'd3,
      OP_REMOVE       = 3'd4,
      OP_CLEAR        = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic count_we;
      logic has_result;
   } update_ctl_type;

endpackage
`default_nettype wire

// File: rtl/core/wcc_req_if.sv
// Request channel interface: valid, ready and one input item.
`default_nettype none
interface wcc_req_if;
   logic                             valid;
   logic                             ready;
   logic [wcc_pkg::OP_BITS-1:0]      op;
   logic [wcc_pkg::INDEX_BITS-1:0]   neighbor_index;
   logic [wcc_pkg::WEIGHT_BITS-1:0]  weight_value;
   logic                             last;

   modport source (output valid, output op, output neighbor_index, output weight_value,
                   output last, input ready);
   modport sink   (input valid, input op, input neighbor_index, input weight_value,
                   input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wcc_rsp_if.sv
// Response channel interface: valid, ready and one result item.
`default_nettype none
interface wcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wcc_pkg::ACC_BITS-1:0]  gain;
   logic [wcc_pkg::ACC_BITS-1:0]  total;

   modport source (output valid, output gain, output total, input ready);
   modport sink   (input valid, input gain, input total, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wcc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module wcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/wcc_update.sv
// Read-modify-write arithmetic: count update and saturating gain and total sums.
`default_nettype none
module wcc_update #(
   parameter int COUNT_BITS = wcc_pkg::DEF_COUNT_BITS
) (
   input  wire wcc_pkg::op_type                    op,
   input  wire logic                               index_ok,
   input  wire logic                               last,
   input  wire logic [COUNT_BITS-1:0]              count,
   input  wire logic [wcc_pkg::WEIGHT_BITS-1:0]    weight,
   input  wire logic [wcc_pkg::ACC_BITS-1:0]       gain,
   input  wire logic [wcc_pkg::ACC_BITS-1:0]       total,
   output logic      [COUNT_BITS-1:0]              count_next,
   output logic      [wcc_pkg::ACC_BITS-1:0]       gain_next,
   output logic      [wcc_pkg::ACC_BITS-1:0]       total_next,
   output wcc_pkg::update_ctl_type                 ctl
);

   localparam int AB = wcc_pkg::ACC_BITS;

   logic          count_zero;
   logic          count_one;
   logic          count_top;
   logic [AB-1:0] weight_wide;
   logic [AB:0]   gain_sum;
   logic [AB:0]   total_sum;
   logic [AB-1:0] gain_sat;
   logic [AB-1:0] total_sat;
   logic [AB-1:0] total_less;

   assign count_zero  = (count == '0);
   assign count_one   = (count == COUNT_BITS'(1));
   assign count_top   = &count;
   assign weight_wide = {{(AB - wcc_pkg::WEIGHT_BITS){1'b0}}, weight};
   assign gain_sum    = {1'b0, gain} + {1'b0, weight_wide};
   assign total_sum   = {1'b0, total} + {1'b0, weight_wide};
   assign gain_sat    = gain_sum[AB] ? wcc_pkg::ACC_MAX : gain_sum[AB-1:0];
   assign total_sat   = total_sum[AB] ? wcc_pkg::ACC_MAX : total_sum[AB-1:0];
   assign total_less  = (total > weight_wide) ? (total - weight_wide) : '0;

   always_comb begin
      count_next     = count;
      gain_next      = gain;
      total_next     = total;
      ctl.count_we   = 1'b0;
      ctl.has_result = 1'b0;
      unique case (op)
         wcc_pkg::OP_GAIN_ADD: begin
            ctl.has_result = last;
            if (index_ok && count_zero) begin
               gain_next = gain_sat;
            end
         end
         wcc_pkg::OP_GAIN_REMOVE: begin
            ctl.has_result = last;
            if (index_ok && count_one) begin
               gain_next = gain_sat;
            end
         end
         wcc_pkg::OP_ADD: begin
            ctl.has_result = last;
            if (index_ok) begin
               if (count_zero) begin
                  gain_next  = gain_sat;
                  total_next = total_sat;
               end
               if (!count_top) begin
                  count_next   = count + COUNT_BITS'(1);
                  ctl.count_we = 1'b1;
               end
            end
         end
         wcc_pkg::OP_REMOVE: begin
            ctl.has_result = last;
            if (index_ok) begin
               if (count_one) begin
                  gain_next  = gain_sat;
                  total_next = total_less;
               end
               if (!count_zero) begin
                  count_next   = count - COUNT_BITS'(1);
                  ctl.count_we = 1'b1;
               end
            end
         end
         default: begin
            // Weight writes, clear and unused codes leave counts and sums alone here.
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/weighted_coverage_counter_top.sv
// Top level of the weighted coverage counter: sequencer, sums and the two state memories.
//
// Usage: the request channel carries one transaction per neighbor of a set
// element: an op code, the neighbor index, a weight (used only by weight
// writes) and a last flag. Gain-add, gain-remove, add and remove with last set
// end a run and produce one response transaction holding the gathered gain
// and the covered total, both unsigned Q32.16. Weight writes, clear and the
// unused op codes produce no response.
// Each transaction is read, then written back: the count and weight memories are
// read in the cycle the request is accepted, and the modified count is written
// back in the EXEC state once the transaction may finish; no new request is taken
// while one is in EXEC, and a response enters the output register as it leaves.
// The output register holds a finished response while the next requests are
// taken; only a run-ending transaction that finds the register still full
// waits until the receiver takes the older response.
// After reset the block runs a clearing pass over every address that sets every
// count to zero and every weight to 1.0; requests are held off until it is done.
// A clear op zeroes the sums and runs the same pass over the counts only.
`default_nettype none
module weighted_coverage_counter_top #(
   parameter int NUM_NEIGHBORS = wcc_pkg::DEF_NUM_NEIGHBORS,
   parameter int COUNT_BITS    = wcc_pkg::DEF_COUNT_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wcc_req_if.sink    req_ch,
   wcc_rsp_if.source  rsp_ch
);

   localparam int ADDR_BITS = $clog2(NUM_NEIGHBORS);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(NUM_NEIGHBORS - 1);
   localparam int AB = wcc_pkg::ACC_BITS;
   localparam int WB = wcc_pkg::WEIGHT_BITS;

   // Control state.
   wcc_pkg::state_type     state_ff, state_in;
   logic [ADDR_BITS-1:0]   sweep_ff, sweep_in;
   logic                   sweep_wt_ff, sweep_wt_in;
   logic [AB-1:0]          gain_ff, gain_in;
   logic [AB-1:0]          total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Captured request and response payload.
   wcc_pkg::op_type        op_ff;
   logic                   index_ok_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [WB-1:0]          wval_ff;
   logic                   last_ff;
   logic [AB-1:0]          rsp_gain_ff, rsp_gain_in;
   logic [AB-1:0]          rsp_total_ff, rsp_total_in;

   logic                   accept;
   logic                   proceed;
   logic [31:0]            index_wide;
   logic [ADDR_BITS-1:0]   req_addr;
   logic                   req_index_ok;

   logic                   cnt_we;
   logic [ADDR_BITS-1:0]   cnt_waddr;
   logic [COUNT_BITS-1:0]  cnt_wdata;
   logic [COUNT_BITS-1:0]  cnt_rdata;
   logic                   wt_we;
   logic [ADDR_BITS-1:0]   wt_waddr;
   logic [WB-1:0]          wt_wdata;
   logic [WB-1:0]          wt_rdata;

   logic [COUNT_BITS-1:0]   count_next;
   logic [AB-1:0]           gain_next;
   logic [AB-1:0]           total_next;
   wcc_pkg::update_ctl_type upd_ctl;

   // Index widened so that it can be both range checked and cut to the address width.
   assign index_wide   = {{(32 - wcc_pkg::INDEX_BITS){1'b0}}, req_ch.neighbor_index};
   assign req_addr     = index_wide[ADDR_BITS-1:0];
   assign req_index_ok = (index_wide < 32'(NUM_NEIGHBORS));

   assign req_ch.ready = (state_ff == wcc_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.gain  = rsp_gain_ff;
   assign rsp_ch.total = rsp_total_ff;

   wcc_update #(
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .op         (op_ff),
      .index_ok   (index_ok_ff),
      .last       (last_ff),
      .count      (cnt_rdata),
      .weight     (wt_rdata),
      .gain       (gain_ff),
      .total      (total_ff),
      .count_next (count_next),
      .gain_next  (gain_next),
      .total_next (total_next),
      .ctl        (upd_ctl)
   );

   // Count memory: one entry per neighbor.
   wcc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_NEIGHBORS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (cnt_rdata)
   );

   // Weight memory: one Q16.16 weight per neighbor.
   wcc_ram #(
      .WIDTH (WB),
      .DEPTH (NUM_NEIGHBORS)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (wt_wdata),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (wt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcc_pkg::ST_SWEEP;
         sweep_ff     <= '0;
         sweep_wt_ff  <= 1'b1;
         gain_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_wt_ff  <= sweep_wt_in;
         gain_ff      <= gain_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= wcc_pkg::op_type'(req_ch.op);
         index_ok_ff <= req_index_ok;
         addr_ff     <= req_addr;
         wval_ff     <= req_ch.weight_value;
         last_ff     <= req_ch.last;
      end
      rsp_gain_ff  <= rsp_gain_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_wt_in  = sweep_wt_ff;
      gain_in      = gain_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_gain_in  = rsp_gain_ff;
      rsp_total_in = rsp_total_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = addr_ff;
      cnt_wdata    = count_next;
      wt_we        = 1'b0;
      wt_waddr     = addr_ff;
      wt_wdata     = wval_ff;
      // A run-ending transaction may only finish when the output register is free or its response is taken now.
      proceed      = !upd_ctl.has_result || !rsp_valid_ff || rsp_ch.ready;

      unique case (state_ff)
         wcc_pkg::ST_SWEEP: begin
            // Clearing pass: counts always, weights only after reset.
            cnt_we    = 1'b1;
            cnt_waddr = sweep_ff;
            cnt_wdata = '0;
            wt_we     = sweep_wt_ff;
            wt_waddr  = sweep_ff;
            wt_wdata  = wcc_pkg::WEIGHT_ONE;
            sweep_in  = sweep_ff + ADDR_BITS'(1);
            if (sweep_ff == LAST_ADDR) begin
               sweep_in    = '0;
               sweep_wt_in = 1'b0;
               state_in    = wcc_pkg::ST_IDLE;
            end
         end
         wcc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = wcc_pkg::ST_EXEC;
            end
         end
         wcc_pkg::ST_EXEC: begin
            // Memory read data for the captured transaction is valid here.
            if (op_ff == wcc_pkg::OP_CLEAR) begin
               gain_in     = '0;
               total_in    = '0;
               sweep_in    = '0;
               sweep_wt_in = 1'b0;
               state_in    = wcc_pkg::ST_SWEEP;
            end else if (proceed) begin
               state_in = wcc_pkg::ST_IDLE;
               wt_we    = (op_ff == wcc_pkg::OP_WRITE_WEIGHT) && index_ok_ff;
               cnt_we   = upd_ctl.count_we;
               total_in = total_next;
               gain_in  = gain_next;
               if (upd_ctl.has_result) begin
                  rsp_valid_in = 1'b1;
                  rsp_gain_in  = gain_next;
                  rsp_total_in = total_next;
                  gain_in      = '0;
               end
            end
         end
         default: begin
            state_in = wcc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
